### hw/rtl/thumb16_instruction_decoder_defines.svh
// assertion macros for the thumb16 decoder rtl
`ifndef THUMB16_INSTRUCTION_DECODER_DEFINES_SVH
`define THUMB16_INSTRUCTION_DECODER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define T16_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent that must hold in the same cycle as the antecedent
`define T16_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define T16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/t16dec_pkg.sv
// shared types and operation codes for the thumb16 decoder
`timescale 1ns / 1ps
`default_nettype none

package t16dec_pkg;

  typedef logic [6:0]  op_t;
  typedef logic [15:0] hw_t;

  typedef struct packed {
    op_t  operation;
    logic wide_prefix;
    logic unpredictable;
    logic ignored;
  } res_t;

  localparam op_t OP_MOV_REG_T2  = 7'd0;
  localparam op_t OP_LSL_IMM     = 7'd1;
  localparam op_t OP_LSR_IMM     = 7'd2;
  localparam op_t OP_ASR_IMM     = 7'd3;
  localparam op_t OP_ADD_REG_T1  = 7'd4;
  localparam op_t OP_MOV_IMM     = 7'd8;
  localparam op_t OP_CMP_IMM     = 7'd9;
  localparam op_t OP_ADD_IMM8    = 7'd10;
  localparam op_t OP_SUB_IMM8    = 7'd11;
  localparam op_t OP_AND         = 7'd12;
  localparam op_t OP_ADD_REG_T2  = 7'd28;
  localparam op_t OP_CMP_REG_T2  = 7'd29;
  localparam op_t OP_MOV_REG_T1  = 7'd30;
  localparam op_t OP_BX          = 7'd31;
  localparam op_t OP_BLX         = 7'd32;
  localparam op_t OP_LDR_LIT     = 7'd33;
  localparam op_t OP_STR_REG     = 7'd34;
  localparam op_t OP_STR_IMM     = 7'd42;
  localparam op_t OP_STRB_IMM    = 7'd44;
  localparam op_t OP_STRH_IMM    = 7'd46;
  localparam op_t OP_STR_SP      = 7'd48;
  localparam op_t OP_ADR         = 7'd50;
  localparam op_t OP_ADD_RD_SP   = 7'd51;
  localparam op_t OP_ADD_SP      = 7'd52;
  localparam op_t OP_SUB_SP      = 7'd53;
  localparam op_t OP_CBZ         = 7'd54;
  localparam op_t OP_SXTH        = 7'd55;
  localparam op_t OP_PUSH        = 7'd59;
  localparam op_t OP_CPS         = 7'd60;
  localparam op_t OP_REV         = 7'd61;
  localparam op_t OP_REV16       = 7'd62;
  localparam op_t OP_REVSH       = 7'd63;
  localparam op_t OP_POP         = 7'd64;
  localparam op_t OP_BKPT        = 7'd65;
  localparam op_t OP_NOP         = 7'd66;
  localparam op_t OP_IT          = 7'd71;
  localparam op_t OP_STM         = 7'd72;
  localparam op_t OP_LDM         = 7'd73;
  localparam op_t OP_UDF         = 7'd74;
  localparam op_t OP_SVC         = 7'd75;
  localparam op_t OP_B_COND      = 7'd76;
  localparam op_t OP_B           = 7'd77;
  localparam op_t OP_HINT_UNALLOC = 7'd78;
  localparam op_t OP_NONE        = 7'd79;

  localparam logic [4:0] WIDE_PFX_A   = 5'b11101;
  localparam logic [4:0] WIDE_PFX_B   = 5'b11110;
  localparam logic [4:0] WIDE_PFX_C   = 5'b11111;
  localparam logic [6:0] MISC_CPS     = 7'b0110011;
  localparam logic [3:0] COND_UDF     = 4'b1110;
  localparam logic [3:0] COND_SVC     = 4'b1111;
  localparam logic [3:0] HINT_LAST    = 4'd4;

endpackage

`default_nettype wire

### hw/rtl/thumb16_instruction_decoder.sv
// thumb16 decoder top level: input register, decode, result register
//
// input channel: in_valid, in_halfword, in_stall; a request moves when
// in_valid is high and in_stall is low. result channel: out_valid,
// out_operation, out_wide_prefix, out_unpredictable, out_ignored and
// out_stall, with the same rule.
// path: a request accepted into the input register is decoded from it and
// lands in the result register when that register advances; out_valid then
// rises, and the result is taken while out_stall is low.
// throughput: one request per cycle while out_stall stays low; the decode
// is a short priority chain of field compares between the two registers.
// when the receiver stalls, the result register holds and the input
// register keeps taking requests until both stages are full; only then is
// in_stall raised, combinationally from out_stall.
// reset clears both stage valid bits; no request is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module thumb16_instruction_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  t16dec_pkg::hw_t  in_halfword,
  output logic             in_stall,
  output logic             out_valid,
  output t16dec_pkg::op_t  out_operation,
  output logic             out_wide_prefix,
  output logic             out_unpredictable,
  output logic             out_ignored,
  input  logic             out_stall
);
  import t16dec_pkg::*;

  `include "thumb16_instruction_decoder_defines.svh"

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  hw_t  s1_hw_r;
  res_t s2_res_r;
  res_t dec_res;
  logic s2_adv;
  logic s1_adv;
  logic in_acc;

  t16dec_decode u_decode (
    .halfword (s1_hw_r),
    .result   (dec_res)
  );

  assign s2_adv   = !s2_v_r || !out_stall;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  assign s1_v_nxt = s1_adv ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_adv ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hw_r <= in_halfword;
    end
    if (s2_adv && s1_v_r) begin
      s2_res_r <= dec_res;
    end
  end

  assign out_valid         = s2_v_r;
  assign out_operation     = s2_res_r.operation;
  assign out_wide_prefix   = s2_res_r.wide_prefix;
  assign out_unpredictable = s2_res_r.unpredictable;
  assign out_ignored       = s2_res_r.ignored;

  `T16_ASSERT_IMPLY(a_stall_full, in_stall, s1_v_r && s2_v_r && out_stall,
                    "stall while not full")
  `T16_ASSERT_IMPLY(a_wide_alone, out_valid && out_wide_prefix,
                    out_operation == OP_NONE && !out_unpredictable && !out_ignored,
                    "wide prefix with other result")
  `T16_ASSERT_IMPLY(a_ign_ops, out_valid && out_ignored,
                    out_operation == OP_BKPT || out_operation == OP_HINT_UNALLOC,
                    "ignored flag on wrong operation")
  `T16_ASSERT_IMPLY(a_unp_none, out_valid && out_unpredictable, out_operation == OP_NONE,
                    "unpredictable with decoded operation")
  `T16_ASSERT_NEXT(a_s1_moves, s1_v_r && !out_stall, s2_v_r, "decoded request lost")
  `T16_ASSERT_ALWAYS(a_op_range, !out_valid || out_operation <= OP_NONE,
                     "operation out of range")

endmodule

`default_nettype wire

### hw/rtl/t16dec_decode.sv
// combinational decode of one thumb halfword into operation and flags
`timescale 1ns / 1ps
`default_nettype none

module t16dec_decode (
  input  t16dec_pkg::hw_t  halfword,
  output t16dec_pkg::res_t result
);
  import t16dec_pkg::*;

  logic [5:0] top;
  logic [4:0] t5;
  logic [4:0] sa_op;
  logic [3:0] sp_op;
  logic [3:0] ls_a;
  logic [2:0] ls_b;
  logic [6:0] m;
  logic [3:0] hint;
  logic [3:0] cond;

  assign top   = halfword[15:10];
  assign t5    = halfword[15:11];
  assign sa_op = halfword[13:9];
  assign sp_op = halfword[9:6];
  assign ls_a  = halfword[15:12];
  assign ls_b  = halfword[11:9];
  assign m     = halfword[11:5];
  assign hint  = halfword[7:4];
  assign cond  = halfword[11:8];

  always_comb begin
    result.operation     = OP_NONE;
    result.wide_prefix   = 1'b0;
    result.unpredictable = 1'b0;
    result.ignored       = 1'b0;
    if (t5 == WIDE_PFX_A || t5 == WIDE_PFX_B || t5 == WIDE_PFX_C) begin
      result.wide_prefix = 1'b1;
    end else if (top[5:4] == 2'b00) begin
      // shift, add, subtract, move, compare
      case (sa_op[4:2])
        3'd0: result.operation = (halfword[10:6] == 5'd0) ? OP_MOV_REG_T2 : OP_LSL_IMM;
        3'd1: result.operation = OP_LSR_IMM;
        3'd2: result.operation = OP_ASR_IMM;
        3'd3: result.operation = OP_ADD_REG_T1 + {5'd0, sa_op[1:0]};
        3'd4: result.operation = OP_MOV_IMM;
        3'd5: result.operation = OP_CMP_IMM;
        3'd6: result.operation = OP_ADD_IMM8;
        default: result.operation = OP_SUB_IMM8;
      endcase
    end else if (top == 6'b010000) begin
      result.operation = OP_AND + {3'd0, sp_op};
    end else if (top == 6'b010001) begin
      // special data and branch exchange
      if (sp_op[3:2] == 2'd0) begin
        result.operation = OP_ADD_REG_T2;
      end else if (sp_op == 4'd4) begin
        result.unpredictable = 1'b1;
      end else if (sp_op[3:2] == 2'd1) begin
        result.operation = OP_CMP_REG_T2;
      end else if (sp_op[3:2] == 2'd2) begin
        result.operation = OP_MOV_REG_T1;
      end else if (sp_op[3:1] == 3'd6) begin
        result.operation = OP_BX;
      end else begin
        result.operation = OP_BLX;
      end
    end else if (t5 == 5'b01001) begin
      result.operation = OP_LDR_LIT;
    end else if (top[5:2] == 4'b0101 || top[5:3] == 3'b011 || top[5:3] == 3'b100) begin
      // load and store single
      case (ls_a)
        4'd5: result.operation = OP_STR_REG + {4'd0, ls_b};
        4'd6: result.operation = OP_STR_IMM + {6'd0, ls_b[2]};
        4'd7: result.operation = OP_STRB_IMM + {6'd0, ls_b[2]};
        4'd8: result.operation = OP_STRH_IMM + {6'd0, ls_b[2]};
        default: result.operation = OP_STR_SP + {6'd0, ls_b[2]};
      endcase
    end else if (t5 == 5'b10100) begin
      result.operation = OP_ADR;
    end else if (t5 == 5'b10101) begin
      result.operation = OP_ADD_RD_SP;
    end else if (top[5:2] == 4'b1011) begin
      // miscellaneous
      if (m[6:2] == 5'd0) begin
        result.operation = OP_ADD_SP;
      end else if (m[6:2] == 5'd1) begin
        result.operation = OP_SUB_SP;
      end else if (m[6:3] inside {4'd1, 4'd3, 4'd9, 4'd11}) begin
        result.operation = OP_CBZ;
      end else if (m[6:3] == 4'd2) begin
        result.operation = OP_SXTH + {5'd0, m[2:1]};
      end else if (m[6:4] == 3'd2) begin
        result.operation = OP_PUSH;
      end else if (m == MISC_CPS) begin
        result.operation = OP_CPS;
      end else if (m[6:1] == 6'h28) begin
        result.operation = OP_REV;
      end else if (m[6:1] == 6'h29) begin
        result.operation = OP_REV16;
      end else if (m[6:1] == 6'h2B) begin
        result.operation = OP_REVSH;
      end else if (m[6:4] == 3'd6) begin
        result.operation = OP_POP;
      end else if (m[6:3] == 4'd14) begin
        result.operation = OP_BKPT;
        result.ignored   = 1'b1;
      end else if (m[6:3] == 4'd15) begin
        // if-then and hints
        if (halfword[3:0] != 4'd0) begin
          result.operation = OP_IT;
        end else if (hint <= HINT_LAST) begin
          result.operation = OP_NOP + {3'd0, hint};
        end else begin
          result.operation = OP_HINT_UNALLOC;
          result.ignored   = 1'b1;
        end
      end else begin
        result.unpredictable = 1'b1;
      end
    end else if (t5 == 5'b11000) begin
      result.operation = OP_STM;
    end else if (t5 == 5'b11001) begin
      result.operation = OP_LDM;
    end else if (top[5:2] == 4'b1101) begin
      case (cond)
        COND_UDF: result.operation = OP_UDF;
        COND_SVC: result.operation = OP_SVC;
        default:  result.operation = OP_B_COND;
      endcase
    end else begin
      result.operation = OP_B;
    end
  end

endmodule

`default_nettype wire

### bench/thumb16_decode_checker.sv
// checker for the thumb16 decoder: predicts each decode and compares results in order
`timescale 1ns / 1ps

module thumb16_decode_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  t16dec_pkg::hw_t  in_halfword,
  input  logic             in_stall,
  input  logic             out_valid,
  input  t16dec_pkg::op_t  out_operation,
  input  logic             out_wide_prefix,
  input  logic             out_unpredictable,
  input  logic             out_ignored,
  input  logic             out_stall,
  output int               pending,
  output int               mismatches,
  output int               n_checked,
  output int               n_wide,
  output int               n_unpred,
  output int               n_ignored
);
  import t16dec_pkg::*;

  typedef struct {
    hw_t  halfword;
    res_t decode;
  } pending_decode_t;

  pending_decode_t pending_decodes[$];

  initial begin
    pending = 0;
    mismatches = 0;
    n_checked = 0;
    n_wide = 0;
    n_unpred = 0;
    n_ignored = 0;
  end

  function automatic res_t decode_misc(input hw_t h);
    res_t r;
    logic [6:0] m;
    r = '{operation: OP_NONE, wide_prefix: 1'b0, unpredictable: 1'b0, ignored: 1'b0};
    m = h[11:5];
    if (m[6:2] == 5'b00000) begin
      r.operation = OP_ADD_SP;
    end else if (m[6:2] == 5'b00001) begin
      r.operation = OP_SUB_SP;
    end else if (!m[5] && m[3]) begin
      r.operation = OP_CBZ;
    end else if (m[6:3] == 4'b0010) begin
      r.operation = OP_SXTH + m[2:1];
    end else if (m[6:4] == 3'b010) begin
      r.operation = OP_PUSH;
    end else if (m == MISC_CPS) begin
      r.operation = OP_CPS;
    end else if (m[6:1] == 6'b101000) begin
      r.operation = OP_REV;
    end else if (m[6:1] == 6'b101001) begin
      r.operation = OP_REV16;
    end else if (m[6:1] == 6'b101011) begin
      r.operation = OP_REVSH;
    end else if (m[6:4] == 3'b110) begin
      r.operation = OP_POP;
    end else if (m[6:3] == 4'b1110) begin
      r.operation = OP_BKPT;
      r.ignored = 1'b1;
    end else if (m[6:3] == 4'b1111) begin
      if (h[3:0] != 4'd0) begin
        r.operation = OP_IT;
      end else if (h[7:4] <= HINT_LAST) begin
        r.operation = OP_NOP + h[7:4];
      end else begin
        r.operation = OP_HINT_UNALLOC;
        r.ignored = 1'b1;
      end
    end else begin
      r.unpredictable = 1'b1;
    end
    return r;
  endfunction

  function automatic res_t decode_halfword(input hw_t h);
    res_t r;
    r = '{operation: OP_NONE, wide_prefix: 1'b0, unpredictable: 1'b0, ignored: 1'b0};
    if (h[15:11] == WIDE_PFX_A || h[15:11] == WIDE_PFX_B || h[15:11] == WIDE_PFX_C) begin
      r.wide_prefix = 1'b1;
    end else if (h[15:14] == 2'b00) begin
      case (h[13:11])
        3'd0: r.operation = (h[10:6] == 5'd0) ? OP_MOV_REG_T2 : OP_LSL_IMM;
        3'd1: r.operation = OP_LSR_IMM;
        3'd2: r.operation = OP_ASR_IMM;
        3'd3: r.operation = OP_ADD_REG_T1 + h[10:9];
        3'd4: r.operation = OP_MOV_IMM;
        3'd5: r.operation = OP_CMP_IMM;
        3'd6: r.operation = OP_ADD_IMM8;
        default: r.operation = OP_SUB_IMM8;
      endcase
    end else if (h[15:10] == 6'b010000) begin
      r.operation = OP_AND + h[9:6];
    end else if (h[15:10] == 6'b010001) begin
      if (h[9:8] == 2'b00) begin
        r.operation = OP_ADD_REG_T2;
      end else if (h[9:6] == 4'b0100) begin
        r.unpredictable = 1'b1;
      end else if (h[9:8] == 2'b01) begin
        r.operation = OP_CMP_REG_T2;
      end else if (h[9:8] == 2'b10) begin
        r.operation = OP_MOV_REG_T1;
      end else if (h[9:7] == 3'b110) begin
        r.operation = OP_BX;
      end else begin
        r.operation = OP_BLX;
      end
    end else if (h[15:11] == 5'b01001) begin
      r.operation = OP_LDR_LIT;
    end else if (h[15:12] == 4'b0101) begin
      r.operation = OP_STR_REG + h[11:9];
    end else if (h[15:13] == 3'b011) begin
      r.operation = (h[12] ? OP_STRB_IMM : OP_STR_IMM) + h[11];
    end else if (h[15:12] == 4'b1000) begin
      r.operation = OP_STRH_IMM + h[11];
    end else if (h[15:12] == 4'b1001) begin
      r.operation = OP_STR_SP + h[11];
    end else if (h[15:11] == 5'b10100) begin
      r.operation = OP_ADR;
    end else if (h[15:11] == 5'b10101) begin
      r.operation = OP_ADD_RD_SP;
    end else if (h[15:12] == 4'b1011) begin
      r = decode_misc(h);
    end else if (h[15:11] == 5'b11000) begin
      r.operation = OP_STM;
    end else if (h[15:11] == 5'b11001) begin
      r.operation = OP_LDM;
    end else if (h[15:12] == 4'b1101) begin
      if (h[11:8] == COND_UDF) begin
        r.operation = OP_UDF;
      end else if (h[11:8] == COND_SVC) begin
        r.operation = OP_SVC;
      end else begin
        r.operation = OP_B_COND;
      end
    end else begin
      r.operation = OP_B;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pending_decode_t want;
    res_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{operation: out_operation, wide_prefix: out_wide_prefix,
                unpredictable: out_unpredictable, ignored: out_ignored};
        if (pending_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: op %0d wide %0b unp %0b ign %0b",
                     got.operation, got.wide_prefix, got.unpredictable, got.ignored);
          end
        end else begin
          want = pending_decodes.pop_front();
          n_checked++;
          if (want.decode.wide_prefix) n_wide++;
          if (want.decode.unpredictable) n_unpred++;
          if (want.decode.ignored) n_ignored++;
          if (got.operation !== want.decode.operation ||
              got.wide_prefix !== want.decode.wide_prefix ||
              got.unpredictable !== want.decode.unpredictable ||
              got.ignored !== want.decode.ignored) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch for %h: expected op %0d wide %0b unp %0b ign %0b,",
                       want.halfword, want.decode.operation, want.decode.wide_prefix,
                       want.decode.unpredictable, want.decode.ignored);
              $display("  got op %0d wide %0b unp %0b ign %0b", got.operation,
                       got.wide_prefix, got.unpredictable, got.ignored);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.halfword = in_halfword;
        want.decode = decode_halfword(in_halfword);
        pending_decodes.push_back(want);
      end
      pending = pending_decodes.size();
    end
  end

endmodule

### bench/tb_thumb16_instruction_decoder.sv
// testbench top for the thumb16 decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_thumb16_instruction_decoder;
  import t16dec_pkg::*;

  localparam int N_RANDOM = 1750;
  localparam int N_DIRECTED = 25;

  localparam hw_t DIRECTED_HW [N_DIRECTED] = '{
    16'h0000, 16'h0040, 16'h1C00, 16'h43FF, 16'h4500,
    16'h4700, 16'h4780, 16'h4800, 16'h5FFF, 16'hB080,
    16'hB100, 16'hB660, 16'hB600, 16'hBA00, 16'hBA80,
    16'hBE00, 16'hBF40, 16'hBF50, 16'hBF08, 16'hDE00,
    16'hDFFF, 16'hE7FF, 16'hE800, 16'hF000, 16'hFFFF
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  hw_t  in_halfword = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  op_t  out_operation;
  logic out_wide_prefix;
  logic out_unpredictable;
  logic out_ignored;

  int pending;
  int mismatches;
  int n_checked;
  int n_wide;
  int n_unpred;
  int n_ignored;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thumb16_instruction_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_halfword       (in_halfword),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_operation     (out_operation),
    .out_wide_prefix   (out_wide_prefix),
    .out_unpredictable (out_unpredictable),
    .out_ignored       (out_ignored),
    .out_stall         (out_stall)
  );

  thumb16_decode_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_halfword       (in_halfword),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_operation     (out_operation),
    .out_wide_prefix   (out_wide_prefix),
    .out_unpredictable (out_unpredictable),
    .out_ignored       (out_ignored),
    .out_stall         (out_stall),
    .pending           (pending),
    .mismatches        (mismatches),
    .n_checked         (n_checked),
    .n_wide            (n_wide),
    .n_unpred          (n_unpred),
    .n_ignored         (n_ignored)
  );

  // mostly random, with weight on the misc, hint, special and branch tables
  function automatic hw_t pick_halfword();
    hw_t h;
    int sel;
    h = hw_t'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return h;
    end else if (sel < 65) begin
      h[15:12] = 4'b1011;
    end else if (sel < 75) begin
      h[15:8] = 8'hBF;
      if ($urandom_range(0, 1) == 0) h[3:0] = 4'd0;
    end else if (sel < 85) begin
      h[15:10] = 6'b010001;
    end else if (sel < 93) begin
      h[15:12] = 4'b1101;
    end else begin
      h[15:8] = 8'hBA;
    end
    return h;
  endfunction

  task automatic send_request(input hw_t h);
    in_valid <= 1'b1;
    in_halfword <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: stall rate re-drawn from 0, 20, 50 or 85 percent, with two long hold-offs
  initial begin
    int cyc;
    int stall_pct;
    int hold;
    cyc = 0;
    stall_pct = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (cyc == 400 || cyc == 3000) hold = 80;
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int n;
    int burst;
    int gap;
    n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED_HW[i]) send_request(DIRECTED_HW[i]);
    drain();
    while (n < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < N_RANDOM; k++) begin
        send_request(pick_halfword());
        n++;
        if (n == N_RANDOM / 2) drain();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("decoded %0d directed and %0d random halfwords, %0d results checked",
             N_DIRECTED, N_RANDOM, n_checked);
    $display("results seen: %0d wide prefixes, %0d unpredictable, %0d ignored",
             n_wide, n_unpred, n_ignored);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/t16dec_pkg.sv
hw/rtl/t16dec_decode.sv
hw/rtl/thumb16_instruction_decoder.sv
bench/thumb16_decode_checker.sv
bench/tb_thumb16_instruction_decoder.sv
